### rtl/core/md5d_pkg.sv
// Package with the MD5 constants, round helpers and the control state type.
package md5d_pkg;

  // Initial chaining words A, B, C and D.
  localparam logic [31:0] ChainInit [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Byte appended after the last message byte.
  localparam logic [7:0] PadByte = 8'h80;

  // Bytes in one full message word.
  localparam logic [2:0] FullBytes = 3'd4;

  // Additive constants, one per round.
  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left rotate amounts, indexed by round group and round modulo four.
  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Control states of the digest engine.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_PREF,
    S_ROUND,
    S_ADD,
    S_OUT
  } md5d_state_t;

  // Message word index used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = lo * 4'd5 + 4'd1;
      2'd2:    idx = lo * 4'd3 + 4'd5;
      default: idx = lo * 4'd7;
    endcase
    return idx;
  endfunction

  // 32-bit left rotate.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] x;
    x = {v, v} << s;
    return x[63:32];
  endfunction

endpackage

### rtl/core/md5d_if.sv
// Handshake interfaces for the message word channel and the digest channel.
interface md5d_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface md5d_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

### rtl/core/md5_digest_unit.sv
// A message word is taken in the idle state; each full 64-byte block then runs one buffer
// prefetch, 64 rounds and one chaining add with input held, the rounds in a
// one-round-per-cycle compression loop reading the block buffer memory.
// A last word adds its padding words, one or two compressions, then four items.
// Synchronous reset loads the chaining words and clears position and length, not the buffer.
module md5_digest_unit (
  input  logic            clk,
  input  logic            rst_n,
  md5d_in_if.sink         in_ch,
  md5d_out_if.source      out_ch
);
  import md5d_pkg::*;

  md5d_state_t state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [1:0]  out_idx_r, out_idx_nxt;
  logic        pad_active_r, pad_active_nxt;
  logic        first_r, first_nxt;
  logic        lenok_r, lenok_nxt;
  logic        final_r, final_nxt;
  logic [31:0] pad_word_r, pad_word_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;

  // Block buffer memory and its ports.
  logic [31:0] buf_mem [16];
  logic [31:0] rd_data_r;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [31:0] wr_data;

  // Round datapath signals.
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [31:0] new_b;
  logic [63:0] bit_len;
  logic [2:0]  cnt;
  logic [31:0] last_pad;
  logic        in_fire;
  logic        out_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign bit_len  = {len_r[60:0], 3'b000};

  // Clamp the byte count and build the word that carries the pad byte.
  always_comb begin
    cnt = (in_ch.byte_count > FullBytes) ? FullBytes : in_ch.byte_count;
    unique case (cnt)
      3'd1:    last_pad = {16'h0000, PadByte, in_ch.data_word[7:0]};
      3'd2:    last_pad = {8'h00, PadByte, in_ch.data_word[15:0]};
      3'd3:    last_pad = {PadByte, in_ch.data_word[23:0]};
      default: last_pad = {24'h000000, PadByte};
    endcase
  end

  // One MD5 round on the working words.
  always_comb begin
    unique case (round_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
    t_val = a_r + f_val + rd_data_r + RoundConst[round_r];
    new_b = b_r + rotl32(t_val, RotAmount[{round_r[5:4], round_r[1:0]}]);
  end

  // Next state, buffer writes and handshake outputs.
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    round_nxt      = round_r;
    out_idx_nxt    = out_idx_r;
    pad_active_nxt = pad_active_r;
    first_nxt      = first_r;
    lenok_nxt      = lenok_r;
    final_nxt      = final_r;
    pad_word_nxt   = pad_word_r;
    chain_nxt      = chain_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    wr_en          = 1'b0;
    wr_data        = in_ch.data_word;
    rd_addr        = 4'd0;

    in_ch.ready         = (state_r == S_IDLE);
    out_ch.valid        = (state_r == S_OUT);
    out_ch.digest_word  = chain_r[out_idx_r];
    out_ch.digest_last  = (out_idx_r == 2'd3);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_ch.last_word) begin
            wr_en   = 1'b1;
            pos_nxt = pos_r + 4'd1;
            len_nxt = len_r + 64'd4;
            if (pos_r == 4'd15) begin
              state_nxt = S_PREF;
            end
          end else begin
            len_nxt        = len_r + 64'(cnt);
            pad_active_nxt = 1'b1;
            first_nxt      = 1'b1;
            lenok_nxt      = 1'b0;
            final_nxt      = 1'b0;
            pad_word_nxt   = last_pad;
            state_nxt      = S_PAD;
            // A full last word is stored whole; the pad byte starts the next word.
            if (cnt == FullBytes) begin
              wr_en   = 1'b1;
              pos_nxt = pos_r + 4'd1;
              if (pos_r == 4'd15) begin
                state_nxt = S_PREF;
              end
            end
          end
        end
      end
      S_PAD: begin
        // Push the pad word, then zeros, then the bit length at the last two slots.
        wr_en   = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (first_r) begin
          wr_data   = pad_word_r;
          first_nxt = 1'b0;
          lenok_nxt = (pos_r != 4'd14);
        end else if (lenok_r && pos_r == 4'd14) begin
          wr_data = bit_len[31:0];
        end else if (lenok_r && pos_r == 4'd15) begin
          wr_data   = bit_len[63:32];
          final_nxt = 1'b1;
        end else begin
          wr_data = 32'h0000_0000;
          if (pos_r == 4'd15) begin
            lenok_nxt = 1'b1;
          end
        end
        if (pos_r == 4'd15) begin
          state_nxt = S_PREF;
        end
      end
      S_PREF: begin
        // Fetch the first message word while loading the working words.
        rd_addr   = msg_index(6'd0);
        round_nxt = 6'd0;
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        rd_addr   = msg_index(round_r + 6'd1);
        a_nxt     = d_r;
        d_nxt     = c_r;
        c_nxt     = b_r;
        b_nxt     = new_b;
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        priority if (final_r) begin
          out_idx_nxt = 2'd0;
          state_nxt   = S_OUT;
        end else if (pad_active_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_fire) begin
          out_idx_nxt = out_idx_r + 2'd1;
          if (out_idx_r == 2'd3) begin
            chain_nxt      = ChainInit;
            pos_nxt        = 4'd0;
            len_nxt        = 64'd0;
            pad_active_nxt = 1'b0;
            first_nxt      = 1'b0;
            lenok_nxt      = 1'b0;
            final_nxt      = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and chaining registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= 4'd0;
      len_r        <= 64'd0;
      round_r      <= 6'd0;
      out_idx_r    <= 2'd0;
      pad_active_r <= 1'b0;
      first_r      <= 1'b0;
      lenok_r      <= 1'b0;
      final_r      <= 1'b0;
      chain_r      <= ChainInit;
    end else begin
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      round_r      <= round_nxt;
      out_idx_r    <= out_idx_nxt;
      pad_active_r <= pad_active_nxt;
      first_r      <= first_nxt;
      lenok_r      <= lenok_nxt;
      final_r      <= final_nxt;
      chain_r      <= chain_nxt;
    end
  end

  // Working words and the held pad word.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    pad_word_r <= pad_word_nxt;
  end

  // Block buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[pos_r] <= wr_data;
    end
    rd_data_r <= buf_mem[rd_addr];
  end

  // A compression only starts on a block boundary.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PREF |-> pos_r == 4'd0)
    else $error("compression started off a block boundary");

  // The last round is followed by the chaining add.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && round_r == 6'd63 |=> state_r == S_ADD)
    else $error("round loop did not end in the chaining add");

  // Input and output never handshake together.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a digest item is pending");

  // After the fourth digest item the engine is re-initialized.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_idx_r == 2'd3 |=>
      pos_r == 4'd0 && len_r == 64'd0 && chain_r[0] == ChainInit[0]
      && state_r == S_IDLE)
    else $error("engine not re-initialized after the digest");

endmodule

### dv/tb.sv
// Self-checking testbench for md5_digest_unit: directed and random messages against an MD5 predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int StallLimit = 20000;
  // Quiet cycles after the last digest word, to catch stray output items.
  localparam int TailCycles = 200;
  localparam int TargetWords = 410;

  // Message word item as queued for the driver.
  typedef struct {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
    bit          hold;
  } msg_word_t;

  // One expected digest word.
  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] StartChain [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SineTable [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ShiftTable [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  logic clk;
  logic rst_n;

  md5d_in_if  in_ch ();
  md5d_out_if out_ch ();

  md5_digest_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msg_word_t    pending_words[$];
  digest_word_t digest_exp[$];

  // Predictor state: chaining words, block buffer, slot and byte count.
  logic [31:0] chain_q [4];
  logic [31:0] blk_q [16];
  logic [3:0]  slot_q;
  logic [63:0] len_q;

  int  err_count;
  int  words_taken;
  int  total_words;
  int  idle_cycles;
  bit  in_fire;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void chain_restart();
    for (int k = 0; k < 4; k++) chain_q[k] = StartChain[k];
    slot_q = 4'd0;
    len_q = 64'd0;
  endfunction

  // Sixty-four rounds over the block buffer, added into the chaining words.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t, nb;
    int g;
    int r;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = a + f + blk_q[g] + SineTable[i];
      nb = b + rotate_left(t, ShiftTable[r * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = nb;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
  endfunction

  function automatic void buffer_word(input logic [31:0] w);
    blk_q[slot_q] = w;
    slot_q = slot_q + 4'd1;
    if (slot_q == 4'd0) compress_block();
  endfunction

  // Absorb one accepted message word; a last word pads, finishes and queues the digest.
  function automatic void absorb_word(input logic [31:0] data, input logic [2:0] cnt_in,
                                      input logic last);
    int cnt;
    logic [31:0] w;
    logic [31:0] keep;
    logic [63:0] msg_bits;
    digest_word_t dw;
    cnt = (cnt_in > 3'd4) ? 4 : int'(cnt_in);
    if (!last) begin
      len_q = len_q + 64'd4;
      buffer_word(data);
      return;
    end
    len_q = len_q + 64'(cnt);
    if (cnt == 4) begin
      buffer_word(data);
      w = 32'h80;
    end else if (cnt == 0) begin
      w = 32'h80;
    end else begin
      keep = (32'h1 << (8 * cnt)) - 32'h1;
      w = (data & keep) | (32'h80 << (8 * cnt));
    end
    buffer_word(w);
    // No room left for the length in this block: pad it out and start another.
    if (slot_q > 4'd14) begin
      while (slot_q != 4'd0) buffer_word(32'h0);
    end
    while (slot_q < 4'd14) buffer_word(32'h0);
    msg_bits = len_q << 3;
    buffer_word(msg_bits[31:0]);
    buffer_word(msg_bits[63:32]);
    for (int k = 0; k < 4; k++) begin
      dw.word = chain_q[k];
      dw.last = (k == 3);
      digest_exp.push_back(dw);
    end
    chain_restart();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic logic [31:0] pick_data();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hffffffff;
    return $urandom;
  endfunction

  task automatic add_word(input logic [31:0] data, input logic [2:0] cnt, input logic last,
                          input bit hold);
    msg_word_t m;
    m.data = data;
    m.cnt = cnt;
    m.last = last;
    m.hold = hold;
    pending_words.push_back(m);
  endtask

  // A message of body_words words plus a last word with tail_cnt bytes.
  task automatic add_message(input int body_words, input logic [2:0] tail_cnt,
                             input bit hold_first);
    logic [2:0] c;
    for (int k = 0; k < body_words; k++) begin
      c = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      add_word(pick_data(), c, 1'b0, hold_first && (k == 0));
    end
    add_word(pick_data(), tail_cnt, 1'b1, hold_first && (body_words == 0));
  endtask

  // Idle percentages per phase: sender light then heavy, then none at all.
  function automatic int tx_idle_pct();
    int ph;
    ph = (total_words == 0) ? 0 : (words_taken * 3) / total_words;
    if (ph == 0) return 32;
    if (ph == 1) return 86;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    int ph;
    ph = (total_words == 0) ? 0 : (words_taken * 3) / total_words;
    if (ph == 0) return 86;
    if (ph == 1) return 32;
    return 0;
  endfunction

  // Driver: presents the oldest pending word at the falling edge.
  always @(negedge clk) begin
    bit drive;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_fire) void'(pending_words.pop_front());
      if (in_ch.valid && !in_fire) begin
        drive = 1'b1;
      end else if (pending_words.size() == 0) begin
        drive = 1'b0;
      end else if (pending_words[0].hold && digest_exp.size() != 0) begin
        // Hold off until every outstanding digest word has come out.
        drive = 1'b0;
      end else begin
        drive = ($urandom_range(0, 99) >= tx_idle_pct());
      end
      if (drive && !(in_ch.valid && !in_fire)) begin
        in_ch.data_word  <= pending_words[0].data;
        in_ch.byte_count <= pending_words[0].cnt;
        in_ch.last_word  <= pending_words[0].last;
      end
      in_ch.valid <= drive;
    end
  end

  // Receiver: random backpressure on the digest channel.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
    end
  end

  // Monitor: accepted words feed the predictor, accepted digest words are checked.
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        absorb_word(in_ch.data_word, in_ch.byte_count, in_ch.last_word);
        words_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (digest_exp.size() == 0) begin
          report_mismatch("unexpected digest item", out_ch.digest_word, 32'h0);
        end else begin
          want = digest_exp.pop_front();
          if (out_ch.digest_word !== want.word)
            report_mismatch("digest_word", out_ch.digest_word, want.word);
          if (out_ch.digest_last !== want.last)
            report_mismatch("digest_last", 32'(out_ch.digest_last), 32'(want.last));
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int body;
    int sel;
    err_count = 0;
    words_taken = 0;
    total_words = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_word = 32'h0;
    in_ch.byte_count = 3'd0;
    in_ch.last_word = 1'b0;
    out_ch.ready = 1'b0;
    chain_restart();

    // Directed: empty message, each tail length, oversize counts, a short word
    // that is not last, and a message whose padding spills into a second block.
    add_word($urandom, 3'd0, 1'b1, 1'b0);
    add_word(32'hffffffff, 3'd1, 1'b1, 1'b0);
    add_word(32'h00000000, 3'd2, 1'b1, 1'b0);
    add_word(32'hffffffff, 3'd3, 1'b1, 1'b0);
    add_word(32'hffffffff, 3'd4, 1'b1, 1'b0);
    add_word(32'h00000000, 3'd7, 1'b1, 1'b0);
    add_word(32'hffffffff, 3'd1, 1'b0, 1'b0);
    add_word($urandom, 3'd5, 1'b1, 1'b0);
    add_word(32'hffffffff, 3'd6, 1'b0, 1'b0);
    add_message(12, 3'd4, 1'b0);

    // Random messages; the first one waits for the directed digests to drain.
    add_message($urandom_range(0, 20), 3'($urandom_range(0, 7)), 1'b1);
    while (pending_words.size() < TargetWords) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) body = $urandom_range(0, 20);
      else if (sel < 9) body = $urandom_range(21, 40);
      else body = $urandom_range(0, 3);
      add_message(body, 3'($urandom_range(0, 7)), ($urandom_range(0, 19) == 0));
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0 && digest_exp.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
